// ===== rtl/core/cms_pkg.sv =====
// Package: types, constants and helpers for the confusion matrix statistics unit
package cms_pkg;

    localparam int MAX_CLASSES = 16;
    localparam int COUNT_BITS  = 32;
    localparam int LBL_W       = $clog2(MAX_CLASSES);
    localparam int ADDR_W      = 2 * LBL_W;
    localparam int DEPTH       = MAX_CLASSES * MAX_CLASSES;
    localparam int NCLS_W      = 5;
    localparam int SUM_W       = 64;
    localparam int Q_W         = 17;
    localparam logic [Q_W-1:0] Q_ONE = 17'h10000;
    localparam logic [COUNT_BITS-1:0] CELL_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [1:0] FN_COUNT   = 2'd0;
    localparam logic [1:0] FN_CLEAR   = 2'd1;
    localparam logic [1:0] FN_CLASS   = 2'd2;
    localparam logic [1:0] FN_SUMMARY = 2'd3;

    localparam logic [NCLS_W-1:0] NCLS_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]       func;
        logic [LBL_W-1:0] actual;
        logic [LBL_W-1:0] predicted;
    } in_item_t;

    typedef struct packed {
        logic        status;
        logic [31:0] cell_count;
        logic [31:0] diag_count;
        logic [31:0] row_total;
        logic [31:0] col_total;
        logic [31:0] grand_total;
        logic [16:0] recall_q16;
        logic [16:0] precision_q16;
        logic [16:0] jaccard_q16;
        logic [16:0] accuracy_q16;
        logic [4:0]  classes_present;
        logic        all_present;
    } out_item_t;

    // Command passed from the front to the back through the queue
    typedef struct packed {
        logic [1:0]       func;
        logic             bad;
        logic [LBL_W-1:0] actual;
        logic [LBL_W-1:0] predicted;
    } cmd_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic logic [31:0] clip32(input logic [SUM_W-1:0] x);
        return (|x[SUM_W-1:32]) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

endpackage

// ===== rtl/core/cms_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
module cms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/cms_front.sv =====
// Front end: accepts beats, checks labels, queues commands for the back end
module cms_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  cms_pkg::in_item_t     in_item,
    input  logic [4:0]            n_eff,
    output logic                  q_valid,
    output cms_pkg::cmd_t         q_cmd,
    input  logic                  q_pop
);
    import cms_pkg::*;

    localparam int QD = 2;

    cmd_t          q_mem [QD];
    logic [1:0]    cnt_reg, cnt_next;
    logic          wr_reg, rd_reg;
    cmd_t          cmd;
    logic          do_push;

    // Classify the incoming beat
    always_comb
    begin
        cmd.func      = in_item.func;
        cmd.actual    = in_item.actual;
        cmd.predicted = in_item.predicted;
        cmd.bad       = ({1'b0, in_item.actual} >= n_eff)
                     || ({1'b0, in_item.predicted} >= n_eff);
    end

    assign full    = (cnt_reg == 2'(QD));
    assign do_push = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = q_mem[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !(q_pop && q_valid))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!do_push && q_pop && q_valid)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    // Store queue entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_reg] <= cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(QD))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !q_pop && !full) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count did not advance");
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_valid && !do_push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("queue count did not drop");
endmodule

// ===== rtl/core/cms_divider.sv =====
// Iterative Q1.16 ratio unit: one quotient bit per cycle while busy
module cms_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [16:0] quo
);
    import cms_pkg::*;

    logic        busy_reg;
    logic [4:0]  k_reg;
    logic [63:0] r_reg, d_reg;
    logic [16:0] q_reg;
    logic        done_reg;
    logic [64:0] sh;
    logic        take;

    assign sh   = {r_reg, 1'b0};
    assign take = sh[64] || (sh[63:0] >= d_reg);
    assign done = done_reg;
    assign quo  = q_reg;

    // Restoring division, sixteen steps; a zero divisor gives zero and a ratio of one or more gives one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                d_reg <= den;
                r_reg <= num;
                k_reg <= 5'd0;
                if (den == 64'd0)
                begin
                    q_reg    <= 17'd0;
                    done_reg <= 1'b1;
                end
                else if (num >= den)
                begin
                    q_reg    <= Q_ONE;
                    done_reg <= 1'b1;
                end
                else
                begin
                    q_reg    <= 17'd0;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                r_reg <= take ? (sh[63:0] - d_reg) : sh[63:0];
                q_reg <= {q_reg[15:0], take};
                k_reg <= k_reg + 5'd1;
                if (k_reg == 5'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> q_reg <= Q_ONE)
        else $error("ratio above one");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> !done_reg)
        else $error("done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) start |=> !busy_reg || k_reg == 5'd0)
        else $error("divider step count not restarted");
endmodule

// ===== rtl/core/cms_back.sv =====
// Back end: table updates, clearing sweep and statistics sequencer
module cms_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [4:0]           n_eff,
    input  logic                 q_valid,
    input  cms_pkg::cmd_t        q_cmd,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output cms_pkg::out_item_t   out_item
);
    import cms_pkg::*;

    localparam logic [3:0] S_RST   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CNT   = 4'd2;
    localparam logic [3:0] S_CNTW  = 4'd3;
    localparam logic [3:0] S_CLR   = 4'd4;
    localparam logic [3:0] S_ROW   = 4'd5;
    localparam logic [3:0] S_COL   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DWAIT = 4'd8;
    localparam logic [3:0] S_ACC   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_CELL  = 4'd11;

    logic [3:0]        st_reg;
    cmd_t              cmd_reg;
    logic [ADDR_W:0]   sweep_reg;
    logic [LBL_W:0]    j_reg;
    logic [LBL_W:0]    cls_reg;
    logic [1:0]        dsel_reg;
    logic              rd_pend_reg;
    logic [SUM_W-1:0]  row_reg, col_reg, diag_reg, cell_reg;
    logic [SUM_W-1:0]  dsum_reg, tot_reg;
    logic [21:0]       rsum_reg, psum_reg, jsum_reg;
    logic [16:0]       rq_reg, pq_reg, jq_reg, aq_reg;
    logic [4:0]        pres_reg;
    logic              ovalid_reg;
    out_item_t         out_reg;
    out_item_t         out_next;
    logic              sum_mode;

    // RAM ports
    logic                  we;
    logic [ADDR_W-1:0]     waddr, raddr;
    logic [COUNT_BITS-1:0] wdata, rdata;

    cms_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Divider
    logic        dv_start, dv_done;
    logic [63:0] dv_num, dv_den;
    logic [16:0] dv_q;
    cms_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num),
        .den(dv_den), .done(dv_done), .quo(dv_q)
    );

    logic [SUM_W-1:0] uni;
    assign uni = sat_add(row_reg - ((row_reg >= diag_reg) ? diag_reg : row_reg), col_reg);

    // floor(sum / d) for d in 1..16: multiply by ceil(2^26 / d), exact for sums below 2^21
    function automatic logic [16:0] mean_q16(input logic [21:0] sum, input logic [4:0] d);
        logic [26:0] recip;
        logic [48:0] prod;
        unique case (d)
            5'd1:    recip = 27'd67108864;
            5'd2:    recip = 27'd33554432;
            5'd3:    recip = 27'd22369622;
            5'd4:    recip = 27'd16777216;
            5'd5:    recip = 27'd13421773;
            5'd6:    recip = 27'd11184811;
            5'd7:    recip = 27'd9586981;
            5'd8:    recip = 27'd8388608;
            5'd9:    recip = 27'd7456541;
            5'd10:   recip = 27'd6710887;
            5'd11:   recip = 27'd6100806;
            5'd12:   recip = 27'd5592406;
            5'd13:   recip = 27'd5162221;
            5'd14:   recip = 27'd4793491;
            5'd15:   recip = 27'd4473925;
            default: recip = 27'd4194304;
        endcase
        prod = 49'(sum) * 49'(recip);
        return prod[42:26];
    endfunction

    assign sum_mode = (cmd_reg.func == FN_SUMMARY);
    assign empty    = !ovalid_reg;
    assign out_item = out_reg;
    assign q_pop    = (st_reg == S_IDLE) && q_valid && !ovalid_reg;

    // Drive the RAM address and write port
    always_comb
    begin
        we    = 1'b0;
        waddr = {cmd_reg.actual, cmd_reg.predicted};
        wdata = (rdata == CELL_MAX) ? rdata : rdata + COUNT_BITS'(1);
        raddr = {cmd_reg.actual, cmd_reg.predicted};
        unique case (st_reg)
            S_RST, S_CLR:
            begin
                we    = 1'b1;
                waddr = sweep_reg[ADDR_W-1:0];
                wdata = '0;
            end
            S_CNTW:
            begin
                we = 1'b1;
            end
            S_ROW:
            begin
                raddr = {cls_reg[LBL_W-1:0], j_reg[LBL_W-1:0]};
            end
            S_COL:
            begin
                raddr = {j_reg[LBL_W-1:0], cls_reg[LBL_W-1:0]};
            end
            default:
            begin
            end
        endcase
    end

    // Select divider operands
    always_comb
    begin
        dv_start = (st_reg == S_DIV);
        dv_num   = diag_reg;
        dv_den   = row_reg;
        case (dsel_reg)
            2'd0:
            begin
                dv_num = diag_reg;
                dv_den = row_reg;
            end
            2'd1:
            begin
                dv_num = diag_reg;
                dv_den = col_reg;
            end
            2'd2:
            begin
                dv_num = diag_reg;
                dv_den = uni;
            end
            default:
            begin
                dv_num = dsum_reg;
                dv_den = tot_reg;
            end
        endcase
    end

    // Assemble the result beat: statistics in the output state, else a label error
    always_comb
    begin
        out_next = '0;
        if (st_reg == S_OUT)
        begin
            if (sum_mode)
            begin
                out_next.diag_count      = clip32(dsum_reg);
                out_next.grand_total     = clip32(tot_reg);
                out_next.recall_q16      = (pres_reg == '0) ? '0 :
                                           mean_q16(rsum_reg, pres_reg);
                out_next.precision_q16   = mean_q16(psum_reg, n_eff);
                out_next.jaccard_q16     = mean_q16(jsum_reg, n_eff);
                out_next.accuracy_q16    = aq_reg;
                out_next.classes_present = pres_reg;
                out_next.all_present     = (pres_reg == n_eff);
            end
            else
            begin
                out_next.cell_count    = clip32(cell_reg);
                out_next.diag_count    = clip32(diag_reg);
                out_next.row_total     = clip32(row_reg);
                out_next.col_total     = clip32(col_reg);
                out_next.recall_q16    = rq_reg;
                out_next.precision_q16 = pq_reg;
                out_next.jaccard_q16   = jq_reg;
            end
        end
        else
        begin
            out_next.status = 1'b1;
        end
    end

    // Sequence commands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_RST;
            sweep_reg   <= '0;
            ovalid_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            j_reg       <= '0;
            cls_reg     <= '0;
            dsel_reg    <= 2'd0;
        end
        else
        begin
            if (ovalid_reg && pop)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (st_reg)
                S_RST, S_CLR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == (ADDR_W+1)'(DEPTH - 1))
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        cmd_reg <= q_cmd;
                        if (q_cmd.func == FN_CLEAR)
                        begin
                            sweep_reg <= '0;
                            st_reg    <= S_CLR;
                        end
                        else if (q_cmd.func != FN_SUMMARY && q_cmd.bad)
                        begin
                            out_reg    <= out_next;
                            ovalid_reg <= 1'b1;
                        end
                        else if (q_cmd.func == FN_COUNT)
                        begin
                            st_reg <= S_CNT;
                        end
                        else
                        begin
                            cls_reg     <= q_cmd.func == FN_SUMMARY ? '0 : {1'b0, q_cmd.actual};
                            j_reg       <= '0;
                            row_reg     <= '0;
                            col_reg     <= '0;
                            dsum_reg    <= '0;
                            tot_reg     <= '0;
                            rsum_reg    <= '0;
                            psum_reg    <= '0;
                            jsum_reg    <= '0;
                            pres_reg    <= '0;
                            rd_pend_reg <= 1'b0;
                            st_reg      <= q_cmd.func == FN_SUMMARY ? S_ROW : S_CELL;
                        end
                    end
                end
                S_CNT:
                begin
                    st_reg <= S_CNTW;
                end
                S_CNTW:
                begin
                    st_reg <= S_IDLE;
                end
                S_CELL:
                begin
                    // Cell read is issued at this address in this state and captured in the first row state
                    st_reg <= S_ROW;
                end
                S_ROW, S_COL:
                begin
                    if (st_reg == S_ROW && !rd_pend_reg && j_reg == '0 && !sum_mode)
                    begin
                        cell_reg <= {32'd0, rdata};
                    end
                    if (rd_pend_reg)
                    begin
                        if (st_reg == S_ROW)
                        begin
                            row_reg <= sat_add(row_reg, {32'd0, rdata});
                        end
                        else
                        begin
                            col_reg <= sat_add(col_reg, {32'd0, rdata});
                        end
                        if (j_reg - 1'b1 == cls_reg)
                        begin
                            diag_reg <= {32'd0, rdata};
                        end
                    end
                    if (j_reg == n_eff)
                    begin
                        j_reg       <= '0;
                        rd_pend_reg <= 1'b0;
                        if (st_reg == S_ROW)
                        begin
                            st_reg <= S_COL;
                        end
                        else
                        begin
                            dsel_reg <= 2'd0;
                            st_reg   <= S_DIV;
                        end
                    end
                    else
                    begin
                        j_reg       <= j_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                end
                S_DIV:
                begin
                    st_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (dv_done)
                    begin
                        case (dsel_reg)
                            2'd0: rq_reg <= dv_q;
                            2'd1: pq_reg <= dv_q;
                            2'd2: jq_reg <= (diag_reg == uni) ? Q_ONE : dv_q;
                            default: aq_reg <= dv_q;
                        endcase
                        if (dsel_reg == 2'd2 || dsel_reg == 2'd3)
                        begin
                            st_reg <= (dsel_reg == 2'd3) ? S_OUT : S_ACC;
                        end
                        else
                        begin
                            dsel_reg <= dsel_reg + 2'd1;
                            st_reg   <= S_DIV;
                        end
                    end
                end
                S_ACC:
                begin
                    if (!sum_mode)
                    begin
                        st_reg <= S_OUT;
                    end
                    else
                    begin
                        dsum_reg <= sat_add(dsum_reg, diag_reg);
                        tot_reg  <= sat_add(tot_reg, row_reg);
                        if (row_reg != '0)
                        begin
                            rsum_reg <= rsum_reg + 22'(rq_reg);
                            pres_reg <= pres_reg + 5'd1;
                        end
                        psum_reg <= psum_reg + 22'(pq_reg);
                        jsum_reg <= jsum_reg + 22'(jq_reg);
                        row_reg  <= '0;
                        col_reg  <= '0;
                        if (cls_reg + 1'b1 == n_eff)
                        begin
                            dsel_reg <= 2'd3;
                            st_reg   <= S_DIV;
                        end
                        else
                        begin
                            cls_reg <= cls_reg + 1'b1;
                            st_reg  <= S_ROW;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ovalid_reg)
                    begin
                        out_reg    <= out_next;
                        ovalid_reg <= 1'b1;
                        st_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !ovalid_reg)
        else $error("command taken while result waits");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_OUT && !ovalid_reg) |=> ovalid_reg)
        else $error("result not posted");
    assert property (@(posedge clk) disable iff (!rst_n) we |-> (st_reg != S_IDLE))
        else $error("table write while idle");
endmodule

// ===== rtl/core/confusion_matrix_statistics_unit.sv =====
// Top level: configuration register, front end and back end of the confusion matrix unit
//
// channel  | direction | handshake         | payload
// input    | in        | push / full       | in_item (func, actual, predicted)
// result   | out       | pop / empty       | out_item (status .. all_present)
// config   | in        | APB psel/penable  | num_classes at address 0
//
// A count in the back end reads the table RAM cell, then increments it and writes it back.
// A class query walks the row and column through the single RAM read port
// and runs three 16-step ratio divisions; a summary repeats that for all n classes, then an accuracy division.
// Reset and clear run a sweep zeroing every RAM word; no commands are taken meanwhile.
// The two-entry command queue fills and full rises while the back end is busy.
module confusion_matrix_statistics_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  cms_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output cms_pkg::out_item_t out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cms_pkg::*;

    logic [NCLS_W-1:0] ncls_reg;
    logic [NCLS_W-1:0] n_eff;
    logic              q_valid, q_pop;
    cmd_t              q_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {27'd0, ncls_reg} : 32'd0;

    // Hold the class count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncls_reg <= NCLS_RESET;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            ncls_reg <= pwdata[NCLS_W-1:0];
        end
    end

    // Clamp the class count into range
    assign n_eff = (ncls_reg == '0) ? NCLS_W'(1) :
                   (ncls_reg > NCLS_W'(MAX_CLASSES)) ? NCLS_W'(MAX_CLASSES) : ncls_reg;

    cms_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .n_eff(n_eff), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    cms_back u_back (
        .clk(clk), .rst_n(rst_n), .n_eff(n_eff), .q_valid(q_valid), .q_cmd(q_cmd),
        .q_pop(q_pop), .empty(empty), .pop(pop), .out_item(out_item)
    );
endmodule
